// File: rtl/core/gate_netlist_step_evaluator_defines.svh
// ---------------------------------------------------------------------------
// Gate netlist step evaluator: assertion macros
// Shared concurrent assertion forms, clocked on clk, one of them disabled on rst.
// ---------------------------------------------------------------------------
`ifndef GATE_NETLIST_STEP_EVALUATOR_DEFINES_SVH
`define GATE_NETLIST_STEP_EVALUATOR_DEFINES_SVH

// Check a property outside of reset.
`define GNSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define GNSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/gnse_pkg.sv
// ---------------------------------------------------------------------------
// gnse_pkg
// Types and constants shared by the gate netlist step evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package gnse_pkg;

  localparam int STORE_W   = 64;  // width of the snapshot field
  localparam int IDX_W     = 6;   // width of one variable index
  localparam int LIST_LEN  = 16;  // destination and data list slots
  localparam int SEL_SLOTS = 4;   // select index slots
  localparam int SUM_W     = 4;   // width of a select sum

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_NOT     = 4'd1,
    OP_AND     = 4'd2,
    OP_OR      = 4'd3,
    OP_NAND    = 4'd4,
    OP_NOR     = 4'd5,
    OP_XOR     = 4'd6,
    OP_DECODER = 4'd7,
    OP_MUX     = 4'd8,
    OP_PASS    = 4'd9,
    OP_WRITE   = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_GATE   = 2'd1,
    KIND_DECODE = 2'd2,
    KIND_MUX    = 2'd3
  } kind_t;

  // Truth tables indexed by {a, b}.
  localparam logic [3:0] TT_NOT  = 4'b0011;
  localparam logic [3:0] TT_AND  = 4'b1000;
  localparam logic [3:0] TT_OR   = 4'b1110;
  localparam logic [3:0] TT_NAND = 4'b0111;
  localparam logic [3:0] TT_NOR  = 4'b0001;
  localparam logic [3:0] TT_XOR  = 4'b0110;
  localparam logic [3:0] TT_PASS = 4'b1100;

  typedef struct packed {
    logic [3:0]  operation;
    logic [2:0]  select_count;
    logic [23:0] source_indices;
    logic [4:0]  dest_count;
    logic [47:0] dest_indices_low;
    logic [47:0] dest_indices_high;
    logic [47:0] data_indices_low;
    logic [47:0] data_indices_high;
    logic        write_bit;
  } item_t;

  typedef struct packed {
    logic [STORE_W-1:0] store_snapshot;
    logic               first_dest_bit;
  } result_t;

  // Classified directive handed from front to back.
  typedef struct packed {
    kind_t                              kind;
    logic [3:0]                         truth_table;
    logic [SEL_SLOTS-1:0]               select_en;
    logic [LIST_LEN-1:0]                dest_en;
    logic [SEL_SLOTS-1:0][IDX_W-1:0]    src_idx;
    logic [LIST_LEN-1:0][IDX_W-1:0]     dest_idx;
    logic [LIST_LEN-1:0][IDX_W-1:0]     data_idx;
  } cmd_t;

  function automatic logic [STORE_W-1:0] onehot(input logic [IDX_W-1:0] idx);
    onehot = STORE_W'(1) << idx;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gate_netlist_step_evaluator.sv
// ---------------------------------------------------------------------------
// gate_netlist_step_evaluator
// Evaluates gate directives in netlist order on a store of one-bit variables.
// ---------------------------------------------------------------------------
// Each transaction on the input queue is one gate directive (NOT, AND, OR,
// NAND, NOR, XOR, PASS, decoder, multiplexer or external write); each one
// yields exactly one result transaction holding the whole variable store
// after the step and the new value at the first destination index. The
// block sustains one directive per clock while the result queue has room:
// the front classifies a directive as it is pushed, a two-entry command
// queue holds it, and the back reads the store combinationally and writes
// the store register as it executes, so consecutive directives see each
// other's writes with no bubble. Each directive is registered in the
// command queue and its result, formed by the back, in the two-entry result
// queue, which lets the input keep flowing while results wait. Indices at
// or above VARIABLE_COUNT read as zero and writes to them are dropped.
// Reset clears the store to all zero.
// ---------------------------------------------------------------------------
`default_nettype none

module gate_netlist_step_evaluator import gnse_pkg::*; #(
  parameter int VARIABLE_COUNT = 64,
  parameter int MAX_SELECTS    = 4
) (
  input  wire     clk,
  input  wire     rst,
  input  wire     push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  wire     pop,
  output result_t result
);

  cmd_t    front_cmd;
  cmd_t    back_cmd;
  result_t back_res;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    res_full;
  logic    res_push;

  // Classify each directive on its way in.
  gnse_front #(
    .MAX_SELECTS (MAX_SELECTS)
  ) u_front (
    .item (item),
    .cmd  (front_cmd)
  );

  // Hold classified commands so the back can stall on its own.
  gnse_queue #(
    .ENTRY_T (cmd_t),
    .DEPTH   (2)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .wr_data (front_cmd),
    .pop     (cmd_pop),
    .empty   (cmd_empty),
    .rd_data (back_cmd)
  );

  // Execute one command per cycle against the store while the result queue has room.
  gnse_back #(
    .VARIABLE_COUNT (VARIABLE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // Buffer results until the consumer pops them.
  gnse_queue #(
    .ENTRY_T (result_t),
    .DEPTH   (2)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .full    (res_full),
    .wr_data (back_res),
    .pop     (pop),
    .empty   (empty),
    .rd_data (result)
  );

endmodule

`default_nettype wire

// File: rtl/core/gnse_queue.sv
// ---------------------------------------------------------------------------
// gnse_queue
// Small register FIFO that decouples two stages of the evaluator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "gate_netlist_step_evaluator_defines.svh"

module gnse_queue #(
  parameter type ENTRY_T = logic,
  parameter int  DEPTH   = 2
) (
  input  wire    clk,
  input  wire    rst,
  input  wire    push,
  output logic   full,
  input  ENTRY_T wr_data,
  input  wire    pop,
  output logic   empty,
  output ENTRY_T rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ENTRY_T             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push_ok;
  logic               pop_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) wr_ptr <= wrap_inc(wr_ptr);
      if (pop_ok)  rd_ptr <= wrap_inc(rd_ptr);
      case ({push_ok, pop_ok})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk) begin
    if (push_ok) entries[wr_ptr] <= wr_data;
  end

  `GNSE_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "queue count past depth")
  `GNSE_ASSERT(a_count_up, push_ok && !pop_ok |=> count == $past(count) + CNT_W'(1), "queue count missed a push")
  `GNSE_ASSERT(a_count_down, pop_ok && !push_ok |=> count == $past(count) - CNT_W'(1), "queue count missed a pop")

endmodule

`default_nettype wire

// File: rtl/core/gnse_front.sv
// ---------------------------------------------------------------------------
// gnse_front
// Classify an incoming gate directive into an execution command.
// ---------------------------------------------------------------------------
`default_nettype none

module gnse_front import gnse_pkg::*; #(
  parameter int MAX_SELECTS = 4
) (
  input  item_t item,
  output cmd_t  cmd
);

  always_comb begin
    cmd.kind        = KIND_NONE;
    cmd.truth_table = '0;
    case (item.operation)
      OP_NOT:     begin cmd.kind = KIND_GATE; cmd.truth_table = TT_NOT;  end
      OP_AND:     begin cmd.kind = KIND_GATE; cmd.truth_table = TT_AND;  end
      OP_OR:      begin cmd.kind = KIND_GATE; cmd.truth_table = TT_OR;   end
      OP_NAND:    begin cmd.kind = KIND_GATE; cmd.truth_table = TT_NAND; end
      OP_NOR:     begin cmd.kind = KIND_GATE; cmd.truth_table = TT_NOR;  end
      OP_XOR:     begin cmd.kind = KIND_GATE; cmd.truth_table = TT_XOR;  end
      OP_PASS:    begin cmd.kind = KIND_GATE; cmd.truth_table = TT_PASS; end
      OP_WRITE:   begin cmd.kind = KIND_GATE; cmd.truth_table = {4{item.write_bit}}; end
      OP_DECODER: cmd.kind = KIND_DECODE;
      OP_MUX:     cmd.kind = KIND_MUX;
      default:    cmd.kind = KIND_NONE;
    endcase

    // Clamp select and output counts into per-slot enables.
    for (int q = 0; q < SEL_SLOTS; q++) begin
      cmd.select_en[q] = (3'(q) < item.select_count) && (q < MAX_SELECTS);
    end
    for (int q = 0; q < LIST_LEN; q++) begin
      cmd.dest_en[q] = (5'(q) < item.dest_count);
    end

    cmd.src_idx  = item.source_indices;
    cmd.dest_idx = {item.dest_indices_high, item.dest_indices_low};
    cmd.data_idx = {item.data_indices_high, item.data_indices_low};
  end

endmodule

`default_nettype wire

// File: rtl/core/gnse_back.sv
// ---------------------------------------------------------------------------
// gnse_back
// Variable store and combinational execution of one command against it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "gate_netlist_step_evaluator_defines.svh"

module gnse_back import gnse_pkg::*; #(
  parameter int VARIABLE_COUNT = 64
) (
  input  wire     clk,
  input  wire     rst,
  input  cmd_t    cmd,
  input  wire     cmd_valid,
  output logic    cmd_pop,
  input  wire     res_full,
  output logic    res_push,
  output result_t res
);

  logic [VARIABLE_COUNT-1:0] store;
  logic [VARIABLE_COUNT-1:0] store_next;
  logic [STORE_W-1:0]        store_ext;
  logic [STORE_W-1:0]        new_ext;
  logic [STORE_W-1:0]        snap;
  logic [STORE_W-1:0]        all_mask;
  logic [STORE_W-1:0]        later_mask;
  logic [STORE_W-1:0]        set_mask;
  logic [STORE_W-1:0]        d0_mask;
  logic [SUM_W-1:0]          sel_sum;
  logic                      op_a;
  logic                      op_b;
  logic                      gate_val;
  logic                      mux_val;
  logic                      exec;

  assign exec     = cmd_valid && !res_full;
  assign cmd_pop  = exec;
  assign res_push = exec;

  // Bits beyond the store read as zero.
  assign store_ext = STORE_W'(store);
  assign op_a      = store_ext[cmd.src_idx[0]];
  assign op_b      = store_ext[cmd.src_idx[1]];
  assign gate_val  = cmd.truth_table[{op_a, op_b}];
  assign d0_mask   = onehot(cmd.dest_idx[0]);

  always_comb begin
    for (int q = 0; q < SEL_SLOTS; q++) begin
      sel_sum[q] = cmd.select_en[q] && store_ext[cmd.src_idx[q]];
    end
  end

  assign mux_val = store_ext[cmd.data_idx[sel_sum]];

  // Decoder: the selected output survives unless a later slot hits it.
  always_comb begin
    all_mask   = '0;
    later_mask = '0;
    for (int q = 0; q < LIST_LEN; q++) begin
      if (cmd.dest_en[q]) begin
        all_mask = all_mask | onehot(cmd.dest_idx[q]);
        if (SUM_W'(q) > sel_sum) later_mask = later_mask | onehot(cmd.dest_idx[q]);
      end
    end
    set_mask = cmd.dest_en[sel_sum] ? onehot(cmd.dest_idx[sel_sum]) : '0;
  end

  always_comb begin
    case (cmd.kind)
      KIND_GATE:   new_ext = (store_ext & ~d0_mask) | (gate_val ? d0_mask : '0);
      KIND_MUX:    new_ext = (store_ext & ~d0_mask) | (mux_val ? d0_mask : '0);
      KIND_DECODE: new_ext = (store_ext & ~all_mask) | (set_mask & ~later_mask);
      default:     new_ext = store_ext;
    endcase
  end

  // Drop writes past the last variable.
  assign store_next         = new_ext[VARIABLE_COUNT-1:0];
  assign snap               = STORE_W'(store_next);
  assign res.store_snapshot = snap;
  assign res.first_dest_bit = snap[cmd.dest_idx[0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      store <= '0;
    end else if (exec) begin
      store <= store_next;
    end
  end

  `GNSE_ASSERT_ALWAYS(a_store_reset, $past(rst) |-> store == '0, "store not cleared by reset")
  `GNSE_ASSERT(a_store_hold, !exec |=> store == $past(store), "store changed without a command")
  `GNSE_ASSERT(a_gate_one_bit, exec && cmd.kind == KIND_GATE |=> $countones(store ^ $past(store)) <= 1, "gate changed more than one variable")

endmodule

`default_nettype wire
